// ----- hw/rtl/smu_pkg.sv -----
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types and constants for the small matrix unit.
// ----------------------------------------------------------------------------
package smu_pkg;

    localparam int MAX_DIM_DEF   = 3;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DIM_W  = 2;
    localparam int DATA_W = 32;
    // three products of two 32-bit values never leave 66 bits
    localparam int ACC_W  = 2 * DATA_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd3;

    localparam logic [2:0] OP_MUL   = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_TRANS = 3'd3;
    localparam logic [2:0] OP_SCALE = 3'd4;

    localparam logic [1:0] KIND_WR_A    = 2'd0;
    localparam logic [1:0] KIND_WR_B    = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic [1:0]               row;
        logic [1:0]               col;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               out_row;
        logic [1:0]               out_col;
        logic signed [DATA_W-1:0] out_value;
        logic                     saturated;
        logic                     last;
    } res_t;

endpackage

// ----- hw/rtl/smu_stream_if.sv -----
// ----------------------------------------------------------------------------
// smu_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface smu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/small_matrix_unit_top.sv -----
// Load items: one accepted per cycle while the unit is idle; cmd.ready is low during compute.
// Compute: each result element runs the shared read/multiply/accumulate sequence for K terms
// (K = inner_dim for multiply, else 1), then a finish state that holds through any output stall.
// Reset idles control and presets configuration to multiply, 3x3x3; operand stores are undefined until written.
// ----------------------------------------------------------------------------
// small_matrix_unit_top
// Small fixed-point matrix unit: element loads into A and B, then multiply,
// add, subtract, transpose or scale through one shared arithmetic unit.
// ----------------------------------------------------------------------------
module small_matrix_unit_top #(
    parameter int MAX_DIM   = smu_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = smu_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [smu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smu_pkg::CFG_DATA_W-1:0]  cfg_data,
    smu_stream_if.sink                      cmd,
    smu_stream_if.source                    res
);

    localparam int SLOTS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int ACC_W  = smu_pkg::ACC_W;
    localparam int DATA_W = smu_pkg::DATA_W;
    localparam int DIM_W  = smu_pkg::DIM_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    function automatic logic [ADDR_W-1:0] slot(input logic [DIM_W-1:0] r,
                                               input logic [DIM_W-1:0] c);
        slot = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
    endfunction

    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (4'(d) > 4'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        dim_clamp = r;
    endfunction

    state_t                     state_reg, state_next;
    logic [2:0]                 op_mode_reg;
    logic [DIM_W-1:0]           rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [DIM_W-1:0]           i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [DATA_W-1:0]   rd_a_reg, rd_b_reg;
    logic signed [ACC_W-1:0]    prod_reg, prod_next, acc_reg, acc_next;
    logic                       res_valid_reg, res_valid_next;
    smu_pkg::res_t              res_data_reg, res_data_next;

    logic signed [DATA_W-1:0]   mem_a [SLOTS];
    logic signed [DATA_W-1:0]   mem_b [SLOTS];

    logic                       cmd_fire, wr_ok, op_valid, is_last, frac_mode;
    logic [DIM_W-1:0]           ra, kd, cb, nr, nc, ks;
    logic [ADDR_W-1:0]          addr_a, addr_b, wr_addr;
    logic signed [2*DATA_W-1:0] mul_full;
    logic signed [DATA_W:0]     add_full;
    logic signed [ACC_W-1:0]    unit_out, shifted;
    logic [ACC_W-DATA_W:0]      top_bits;
    logic                       fits;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    assign ra = dim_clamp(rows_a_reg);
    assign kd = dim_clamp(inner_dim_reg);
    assign cb = dim_clamp(cols_b_reg);

    assign op_valid  = (op_mode_reg <= smu_pkg::OP_SCALE);
    assign frac_mode = (op_mode_reg == smu_pkg::OP_MUL) || (op_mode_reg == smu_pkg::OP_SCALE);

    always_comb
    begin
        nr = ra;
        nc = kd;
        ks = DIM_W'(1);
        case (op_mode_reg)
            smu_pkg::OP_MUL:
            begin
                nc = cb;
                ks = kd;
            end
            smu_pkg::OP_TRANS:
            begin
                nr = kd;
                nc = ra;
            end
            default:
            begin
                nr = ra;
            end
        endcase
    end

    always_comb
    begin
        addr_a = slot(i_reg, j_reg);
        addr_b = slot(i_reg, j_reg);
        case (op_mode_reg)
            smu_pkg::OP_MUL:
            begin
                addr_a = slot(i_reg, k_reg);
                addr_b = slot(k_reg, j_reg);
            end
            smu_pkg::OP_TRANS:
            begin
                addr_a = slot(j_reg, i_reg);
            end
            smu_pkg::OP_SCALE:
            begin
                addr_b = '0;
            end
            default:
            begin
                addr_b = slot(i_reg, j_reg);
            end
        endcase
    end

    assign wr_ok   = (4'(cmd.data.row) < 4'(MAX_DIM)) && (4'(cmd.data.col) < 4'(MAX_DIM));
    assign wr_addr = slot(cmd.data.row, cmd.data.col);

    // operand stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd_fire && wr_ok && (cmd.data.kind == smu_pkg::KIND_WR_A))
        begin
            mem_a[wr_addr] <= cmd.data.value;
        end
        if (cmd_fire && wr_ok && (cmd.data.kind == smu_pkg::KIND_WR_B))
        begin
            mem_b[wr_addr] <= cmd.data.value;
        end
        if (state_reg == ST_READ)
        begin
            rd_a_reg <= mem_a[addr_a];
            rd_b_reg <= mem_b[addr_b];
        end
    end

    // shared arithmetic unit
    always_comb
    begin
        mul_full = rd_a_reg * rd_b_reg;
        add_full = (op_mode_reg == smu_pkg::OP_SUB)
                 ? $signed({rd_a_reg[DATA_W-1], rd_a_reg}) - $signed({rd_b_reg[DATA_W-1], rd_b_reg})
                 : $signed({rd_a_reg[DATA_W-1], rd_a_reg}) + $signed({rd_b_reg[DATA_W-1], rd_b_reg});
        case (op_mode_reg)
            smu_pkg::OP_ADD, smu_pkg::OP_SUB:
                unit_out = {{(ACC_W-DATA_W-1){add_full[DATA_W]}}, add_full};
            smu_pkg::OP_TRANS:
                unit_out = {{(ACC_W-DATA_W){rd_a_reg[DATA_W-1]}}, rd_a_reg};
            default:
                unit_out = {{(ACC_W-2*DATA_W){mul_full[2*DATA_W-1]}}, mul_full};
        endcase
    end

    // floor shift (multiply and scale only) and saturation to 32 bits
    assign shifted  = frac_mode ? (acc_reg >>> FRAC_BITS) : acc_reg;
    assign top_bits = shifted[ACC_W-1:DATA_W-1];
    assign fits     = (&top_bits) || !(|top_bits);
    assign is_last  = (i_reg == DIM_W'(nr - DIM_W'(1))) && (j_reg == DIM_W'(nc - DIM_W'(1)));

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_data_next  = res_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.data.kind == smu_pkg::KIND_COMPUTE) && op_valid)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = unit_out;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next = (k_reg == '0) ? prod_reg : acc_reg + prod_reg;
                if (k_reg == DIM_W'(ks - DIM_W'(1)))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    k_next     = DIM_W'(k_reg + DIM_W'(1));
                    state_next = ST_READ;
                end
            end
            ST_FIN:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next          = 1'b1;
                    res_data_next.out_row   = i_reg;
                    res_data_next.out_col   = j_reg;
                    res_data_next.saturated = !fits;
                    res_data_next.last      = is_last;
                    if (fits)
                    begin
                        res_data_next.out_value = shifted[DATA_W-1:0];
                    end
                    else if (shifted[ACC_W-1])
                    begin
                        res_data_next.out_value = {1'b1, {(DATA_W-1){1'b0}}};
                    end
                    else
                    begin
                        res_data_next.out_value = {1'b0, {(DATA_W-1){1'b1}}};
                    end
                    k_next = '0;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                        if (j_reg == DIM_W'(nc - DIM_W'(1)))
                        begin
                            j_next = '0;
                            i_next = DIM_W'(i_reg + DIM_W'(1));
                        end
                        else
                        begin
                            j_next = DIM_W'(j_reg + DIM_W'(1));
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            op_mode_reg   <= smu_pkg::OP_MUL;
            rows_a_reg    <= DIM_W'(3);
            inner_dim_reg <= DIM_W'(3);
            cols_b_reg    <= DIM_W'(3);
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    smu_pkg::CFG_OP_MODE:   op_mode_reg   <= cfg_data;
                    smu_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data[DIM_W-1:0];
                    smu_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_data[DIM_W-1:0];
                    smu_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data[DIM_W-1:0];
                    default:                op_mode_reg   <= op_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        res_data_reg <= res_data_next;
    end

`ifndef SYNTH
    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (i_reg < nr) && (j_reg < nc) && (k_reg < ks))
        else $error("element counters outside result shape");

    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.data.kind == smu_pkg::KIND_COMPUTE) && op_valid)
        |=> (state_reg == ST_READ))
        else $error("compute transfer did not start the sequencer");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.data.kind != smu_pkg::KIND_COMPUTE)) |=> (state_reg == ST_IDLE))
        else $error("load transfer left the idle state");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && (!res_valid_reg || res.ready) && is_last)
        |=> (state_reg == ST_IDLE) && res_valid_reg && res_data_reg.last)
        else $error("final element not marked or run not ended");
`endif

endmodule
